@@ hw/rtl/gsp_pkg.sv @@
// Shared types, widths, register indexes and reset values for the
// gain-scheduled PID steering block. No dependencies.

package gsp_pkg;

    localparam int ERR_W      = 16;   // track error, signed Q8.8
    localparam int MAG_W      = 17;   // |error|, unsigned Q9.8
    localparam int DIFF_W     = 17;   // error difference, signed
    localparam int SUM_W      = 32;   // running error sum, signed
    localparam int GAIN_W     = 24;   // gains, unsigned Q8.16
    localparam int THR_W      = 15;   // thresholds, unsigned Q7.8
    localparam int CMD_W      = 16;   // steering command, signed Q2.14
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int MUL_A_W = GAIN_W + 1;
    localparam int MUL_B_W = SUM_W;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = PROD_W + 1;

    // Interpolation divider: quotient bits retired per cycle
    localparam int DIV_STEP   = 4;
    localparam int DIV_CYCLES = GAIN_W / DIV_STEP;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [CFG_IDX_W-1:0] REG_KP_MIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KP_MAX   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KI_MIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KI_MAX   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KD_MIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_KD_MAX   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_THR_LOW  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_THR_HIGH = 3'd7;

    localparam logic [GAIN_W-1:0] KP_MIN_RST   = 24'd5243;
    localparam logic [GAIN_W-1:0] KP_MAX_RST   = 24'd10486;
    localparam logic [GAIN_W-1:0] KI_MIN_RST   = 24'd66;
    localparam logic [GAIN_W-1:0] KI_MAX_RST   = 24'd131;
    localparam logic [GAIN_W-1:0] KD_MIN_RST   = 24'd65536;
    localparam logic [GAIN_W-1:0] KD_MAX_RST   = 24'd131072;
    localparam logic [THR_W-1:0]  THR_LOW_RST  = 15'd51;
    localparam logic [THR_W-1:0]  THR_HIGH_RST = 15'd307;

    localparam logic signed [CMD_W-1:0] CMD_POS_ONE = 16'sd16384;
    localparam logic signed [CMD_W-1:0] CMD_NEG_ONE = -16'sd16384;
    localparam logic signed [ACC_W-1:0] ACC_POS_ONE = ACC_W'(64'sd16777216);
    localparam logic signed [ACC_W-1:0] ACC_NEG_ONE = ACC_W'(-64'sd16777216);

    typedef enum logic [1:0] {
        ZONE_LOW,
        ZONE_MID,
        ZONE_HIGH
    } zone_t;

    typedef struct packed {
        logic [GAIN_W-1:0] kp_min;
        logic [GAIN_W-1:0] kp_max;
        logic [GAIN_W-1:0] ki_min;
        logic [GAIN_W-1:0] ki_max;
        logic [GAIN_W-1:0] kd_min;
        logic [GAIN_W-1:0] kd_max;
        logic [THR_W-1:0]  thr_low;
        logic [THR_W-1:0]  thr_high;
    } cfg_t;

    typedef struct packed {
        logic signed [ERR_W-1:0]  err;
        logic signed [DIFF_W-1:0] diff;
        logic signed [SUM_W-1:0]  sum;
        zone_t                    zone;
        logic [THR_W-1:0]         offset;   // |error| - low threshold, mid zone only
    } job_t;

endpackage

@@ hw/rtl/gsp_ifs.sv @@
// Valid/ready channel interfaces for samples, steering results and
// configuration writes. Depends on gsp_pkg.

interface gsp_sample_if import gsp_pkg::*; ;
    logic                    valid;
    logic                    ready;
    logic signed [ERR_W-1:0] track_error;

    modport source (output valid, output track_error, input ready);
    modport sink (input valid, input track_error, output ready);
endinterface

interface gsp_steer_if import gsp_pkg::*; ;
    logic                    valid;
    logic                    ready;
    logic signed [CMD_W-1:0] steer_command;
    logic                    steer_clamped;

    modport source (output valid, output steer_command, output steer_clamped, input ready);
    modport sink (input valid, input steer_command, input steer_clamped, output ready);
endinterface

interface gsp_cfg_if import gsp_pkg::*; ;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/gsp_front.sv @@
// Front end: accepts error samples, updates derivative and integral state,
// classifies the gain zone and pushes a job. Depends on gsp_pkg, gsp_ifs.

module gsp_front import gsp_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    gsp_sample_if.sink       sample,
    input  cfg_t             cfg,
    input  logic             full,
    output logic             push,
    output job_t             job
);

    logic signed [ERR_W-1:0] last_error_reg, last_error_next;
    logic signed [SUM_W-1:0] error_sum_reg, error_sum_next;

    logic signed [MAG_W-1:0] err_ext;
    logic [MAG_W-1:0]        mag;
    logic [MAG_W-1:0]        lo_ext;
    logic [MAG_W-1:0]        hi_ext;
    logic [MAG_W-1:0]        off_full;
    logic signed [SUM_W:0]   sum_wide;
    logic signed [SUM_W-1:0] sum_sat;
    zone_t                   zone;

    assign sample.ready = !full;
    assign push         = sample.valid && !full;

    always_comb
    begin
        err_ext  = {sample.track_error[ERR_W-1], sample.track_error};
        mag      = sample.track_error[ERR_W-1] ? MAG_W'(-err_ext) : MAG_W'(err_ext);
        lo_ext   = {{(MAG_W-THR_W){1'b0}}, cfg.thr_low};
        hi_ext   = {{(MAG_W-THR_W){1'b0}}, cfg.thr_high};
        off_full = mag - lo_ext;

        // saturate the integral at the signed 32-bit limits
        sum_wide = {error_sum_reg[SUM_W-1], error_sum_reg}
                 + {{(SUM_W+1-ERR_W){sample.track_error[ERR_W-1]}}, sample.track_error};
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
            sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        else
            sum_sat = sum_wide[SUM_W-1:0];

        if (cfg.thr_high <= cfg.thr_low)
            zone = (mag > lo_ext) ? ZONE_HIGH : ZONE_LOW;
        else if (mag <= lo_ext)
            zone = ZONE_LOW;
        else if (mag >= hi_ext)
            zone = ZONE_HIGH;
        else
            zone = ZONE_MID;

        job.err    = sample.track_error;
        job.diff   = err_ext - {last_error_reg[ERR_W-1], last_error_reg};
        job.sum    = sum_sat;
        job.zone   = zone;
        job.offset = off_full[THR_W-1:0];

        last_error_next = push ? sample.track_error : last_error_reg;
        error_sum_next  = push ? sum_sat : error_sum_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_error_reg <= '0;
            error_sum_reg  <= '0;
        end
        else
        begin
            last_error_reg <= last_error_next;
            error_sum_reg  <= error_sum_next;
        end
    end

endmodule

@@ hw/rtl/gsp_queue.sv @@
// Short job queue between front and back end, register based.
// Depends on gsp_pkg.

module gsp_queue import gsp_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head_job,
    output logic full,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ hw/rtl/gsp_back.sv @@
// Back end: per job, schedules the three gains (shared multiplier plus a
// 4-bit-per-cycle divider), accumulates the PID terms and clamps the result.
// Depends on gsp_pkg, gsp_ifs.

module gsp_back import gsp_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  job_t        job,
    input  logic        empty,
    output logic        pop,
    gsp_steer_if.source steer
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCHED = 3'd1;
    localparam logic [2:0] ST_DIVLD = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_GAIN  = 3'd4;
    localparam logic [2:0] ST_MUL   = 3'd5;
    localparam logic [2:0] ST_ACC   = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    localparam logic [1:0] SEL_P = 2'd0;
    localparam logic [1:0] SEL_I = 2'd1;
    localparam logic [1:0] SEL_D = 2'd2;

    localparam int CNT_W = $clog2(DIV_CYCLES);
    localparam int DVD_W = GAIN_W + THR_W;   // |delta * offset| < span * 2^GAIN_W

    logic [2:0]               state_reg, state_next;
    logic [1:0]               sel_reg, sel_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [THR_W-1:0]         rem_reg, rem_next;
    logic [GAIN_W-1:0]        quo_reg, quo_next;
    logic                     neg_reg, neg_next;
    logic [GAIN_W-1:0]        gain_reg, gain_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [CMD_W-1:0]  out_cmd_reg, out_cmd_next;
    logic                     out_clamp_reg, out_clamp_next;

    logic [GAIN_W-1:0]         gmin, gmax;
    logic signed [MUL_B_W-1:0] term;
    logic signed [MUL_A_W-1:0] delta;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod_next;
    logic [PROD_W-1:0]         prod_abs;
    logic [THR_W-1:0]          span;
    logic [THR_W-1:0]          div_rem;
    logic [GAIN_W-1:0]         div_quo;
    logic [THR_W:0]            trial;
    logic signed [ACC_W-1:0]   raw;
    logic signed [26:0]        rounded;
    logic                      out_free;

    assign steer.valid         = out_valid_reg;
    assign steer.steer_command = out_cmd_reg;
    assign steer.steer_clamped = out_clamp_reg;

    assign out_free = !out_valid_reg || steer.ready;
    assign pop      = (state_reg == ST_OUT) && out_free;

    // gain pair and PID term for the gain being worked on
    always_comb
    begin
        unique case (sel_reg)
            SEL_P:
            begin
                gmin = cfg.kp_min;
                gmax = cfg.kp_max;
                term = MUL_B_W'(job.err);
            end
            SEL_I:
            begin
                gmin = cfg.ki_min;
                gmax = cfg.ki_max;
                term = job.sum;
            end
            SEL_D:
            begin
                gmin = cfg.kd_min;
                gmax = cfg.kd_max;
                term = MUL_B_W'(job.diff);
            end
            default:
            begin
                gmin = '0;
                gmax = '0;
                term = '0;
            end
        endcase
    end

    always_comb
    begin
        delta = $signed({1'b0, gmax}) - $signed({1'b0, gmin});
        span  = cfg.thr_high - cfg.thr_low;

        // one shared multiplier: interpolation product or gain times term
        if (state_reg == ST_SCHED)
        begin
            mul_a = delta;
            mul_b = $signed({{(MUL_B_W-THR_W){1'b0}}, job.offset});
        end
        else
        begin
            mul_a = $signed({1'b0, gain_reg});
            mul_b = term;
        end
        prod_next = mul_a * mul_b;
        prod_abs  = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);

        // restoring division, DIV_STEP quotient bits per cycle
        div_rem = rem_reg;
        div_quo = quo_reg;
        for (int k = 0; k < DIV_STEP; k++)
        begin
            trial   = {div_rem, div_quo[GAIN_W-1]};
            div_quo = {div_quo[GAIN_W-2:0], 1'b0};
            if (trial >= {1'b0, span})
            begin
                div_rem    = THR_W'(trial - {1'b0, span});
                div_quo[0] = 1'b1;
            end
            else
            begin
                div_rem = trial[THR_W-1:0];
            end
        end

        raw     = -acc_reg;
        rounded = $signed({raw[25], raw[25:0]}) + 27'sd512;
    end

    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        neg_next       = neg_reg;
        gain_next      = gain_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && !steer.ready;
        out_cmd_next   = out_cmd_reg;
        out_clamp_next = out_clamp_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    acc_next   = '0;
                    sel_next   = SEL_P;
                    state_next = ST_SCHED;
                end
            end
            ST_SCHED:
            begin
                if (job.zone == ZONE_MID)
                    state_next = ST_DIVLD;
                else
                begin
                    gain_next  = (job.zone == ZONE_HIGH) ? gmax : gmin;
                    state_next = ST_MUL;
                end
            end
            ST_DIVLD:
            begin
                rem_next   = prod_abs[DVD_W-1:GAIN_W];
                quo_next   = prod_abs[GAIN_W-1:0];
                neg_next   = prod_reg[PROD_W-1];
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next = div_rem;
                quo_next = div_quo;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_CYCLES - 1))
                    state_next = ST_GAIN;
            end
            ST_GAIN:
            begin
                // quotient truncates toward zero, so the gain stays between min and max
                gain_next  = neg_reg ? (gmin - quo_reg) : (gmin + quo_reg);
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                acc_next = acc_reg + ACC_W'(prod_reg);
                if (sel_reg == SEL_D)
                    state_next = ST_OUT;
                else
                begin
                    sel_next   = sel_reg + 1'b1;
                    state_next = ST_SCHED;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (raw >= ACC_POS_ONE)
                    begin
                        out_cmd_next   = CMD_POS_ONE;
                        out_clamp_next = 1'b1;
                    end
                    else if (raw <= ACC_NEG_ONE)
                    begin
                        out_cmd_next   = CMD_NEG_ONE;
                        out_clamp_next = 1'b1;
                    end
                    else
                    begin
                        out_cmd_next   = rounded[25:10];
                        out_clamp_next = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg    <= prod_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        neg_reg     <= neg_next;
        gain_reg    <= gain_next;
        acc_reg     <= acc_next;
        out_cmd_reg <= out_cmd_next;
        out_clamp_reg <= out_clamp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sel_reg       <= SEL_P;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ hw/rtl/gain_scheduled_pid_steer.sv @@
// Gain-scheduled PID steering controller. Each accepted track_error sample
// (Q8.8) yields one steer_command (Q2.14, clamped to +-1.0) with a clamp flag.
// The front end takes a sample in the cycle it arrives whenever the job queue
// has room; the back end then handles one job at a time and, per gain, either
// multiplies and accumulates directly when |error| lies outside the threshold
// span or first interpolates the gain. Its pace is set by the single shared
// 25x32 multiplier and the interpolation divider, which retires four quotient
// bits per cycle. Configuration writes are taken in any cycle and must only be
// issued while no item is in flight.
// Depends on gsp_pkg, gsp_ifs, gsp_front, gsp_queue, gsp_back.

module gain_scheduled_pid_steer import gsp_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    gsp_sample_if.sink  sample,
    gsp_steer_if.source steer,
    gsp_cfg_if.sink     cfg
);

    cfg_t cfg_reg, cfg_next;
    job_t push_job, head_job;
    logic push, pop, full, empty;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_KP_MIN:   cfg_next.kp_min   = cfg.data[GAIN_W-1:0];
                REG_KP_MAX:   cfg_next.kp_max   = cfg.data[GAIN_W-1:0];
                REG_KI_MIN:   cfg_next.ki_min   = cfg.data[GAIN_W-1:0];
                REG_KI_MAX:   cfg_next.ki_max   = cfg.data[GAIN_W-1:0];
                REG_KD_MIN:   cfg_next.kd_min   = cfg.data[GAIN_W-1:0];
                REG_KD_MAX:   cfg_next.kd_max   = cfg.data[GAIN_W-1:0];
                REG_THR_LOW:  cfg_next.thr_low  = cfg.data[THR_W-1:0];
                REG_THR_HIGH: cfg_next.thr_high = cfg.data[THR_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp_min   <= KP_MIN_RST;
            cfg_reg.kp_max   <= KP_MAX_RST;
            cfg_reg.ki_min   <= KI_MIN_RST;
            cfg_reg.ki_max   <= KI_MAX_RST;
            cfg_reg.kd_min   <= KD_MIN_RST;
            cfg_reg.kd_max   <= KD_MAX_RST;
            cfg_reg.thr_low  <= THR_LOW_RST;
            cfg_reg.thr_high <= THR_HIGH_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    gsp_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample),
        .cfg    (cfg_reg),
        .full   (full),
        .push   (push),
        .job    (push_job)
    );

    gsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .full     (full),
        .empty    (empty)
    );

    gsp_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .job   (head_job),
        .empty (empty),
        .pop   (pop),
        .steer (steer)
    );

endmodule

@@ hw/rtl/gsp_checker.sv @@
// Port-level checks for gain_scheduled_pid_steer, attached by bind.
// Depends on gsp_pkg.

module gsp_checker import gsp_pkg::*; (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic signed [CMD_W-1:0] steer_command,
    input logic                    steer_clamped
);

    logic [7:0] pending_reg, pending_next;
    logic       in_acc, out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_acc && !out_acc)
            pending_next = pending_reg + 1'b1;
        else if (out_acc && !in_acc)
            pending_next = pending_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_next;
    end

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(steer_command)
                                    && $stable(steer_clamped))
        else $error("steer result changed while stalled");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 8'd0)
        else $error("steer result without a pending sample");

    a_cmd_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> steer_command <= CMD_POS_ONE && steer_command >= CMD_NEG_ONE)
        else $error("steer command outside +-1.0");

    a_clamp_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && steer_clamped |->
            steer_command == CMD_POS_ONE || steer_command == CMD_NEG_ONE)
        else $error("clamp flag set on an unclamped command");

endmodule

bind gain_scheduled_pid_steer gsp_checker u_gsp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (sample.valid),
    .in_ready      (sample.ready),
    .out_valid     (steer.valid),
    .out_ready     (steer.ready),
    .steer_command (steer.steer_command),
    .steer_clamped (steer.steer_clamped)
);
